[src/dtoi_pkg.sv]
// dtoi_pkg: types and constants shared by the decimal text parser modules.
// No dependencies.

package dtoi_pkg;

   // Character classes produced by the front end
   typedef enum logic [2:0] {
      CLS_SPACE,
      CLS_PLUS,
      CLS_MINUS,
      CLS_DIGIT,
      CLS_OTHER,
      CLS_END
   } item_class_type;

   // Result status codes; ST_OK also means "no error" inside the back end
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_INVALID = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PH_LEAD   = 3'b001,
      PH_DIGITS = 3'b010,
      PH_HALT   = 3'b100
   } phase_type;

   typedef struct packed {
      item_class_type cls;
      logic [3:0]     digit;
   } item_type;

   localparam int MagWidth = 127;
   localparam int ValWidth = 128;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [3:0] EDGE_POS = 4'd7;
   localparam logic [3:0] EDGE_NEG = 4'd8;

   // Largest magnitude that can still take one more digit: floor((2^127-1)/10)
   localparam logic [MagWidth-1:0] MAG_LIMIT =
      127'hCCC_CCCC_CCCC_CCCC_CCCC_CCCC_CCCC_CCCC;

endpackage

[src/dtoi_if.sv]
// Channel interfaces for the decimal text parser: character input and result output.
// Depends on nothing.

interface dtoi_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] character;

   modport source (output valid, output action, output character, input ready);
   modport sink   (input valid, input action, input character, output ready);
endinterface

interface dtoi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value_high;
   logic [63:0]        value_low;
   logic [1:0]         status;

   modport source (output valid, output value_high, output value_low, output status,
                   input ready);
   modport sink   (input valid, input value_high, input value_low, input status,
                   output ready);
endinterface

[src/dtoi_front.sv]
// dtoi_front: accepts input transactions and classifies each character.
// Depends on dtoi_pkg and dtoi_req_if.

module dtoi_front (
   dtoi_req_if.sink          req_ch,
   output logic              push_valid,
   input  logic              push_ready,
   output dtoi_pkg::item_type push_item
);

   dtoi_pkg::item_class_type cls;

   always_comb begin
      if (req_ch.action) begin
         cls = dtoi_pkg::CLS_END;
      end else if (req_ch.character inside {[dtoi_pkg::CHAR_ZERO:dtoi_pkg::CHAR_NINE]}) begin
         cls = dtoi_pkg::CLS_DIGIT;
      end else begin
         case (req_ch.character)
            dtoi_pkg::CHAR_SPACE: cls = dtoi_pkg::CLS_SPACE;
            dtoi_pkg::CHAR_PLUS:  cls = dtoi_pkg::CLS_PLUS;
            dtoi_pkg::CHAR_MINUS: cls = dtoi_pkg::CLS_MINUS;
            default:              cls = dtoi_pkg::CLS_OTHER;
         endcase
      end
   end

   // '0'..'9' carry their value in the low nibble
   assign push_item.cls   = cls;
   assign push_item.digit = req_ch.character[3:0];
   assign push_valid      = req_ch.valid;
   assign req_ch.ready    = push_ready;

endmodule

[src/dtoi_queue.sv]
// dtoi_queue: two-entry queue between the classifier and the parse engine.
// Depends on dtoi_pkg.

module dtoi_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  dtoi_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output dtoi_pkg::item_type pop_item
);

   logic [1:0]         count_ff, count_in;
   dtoi_pkg::item_type slot0_ff, slot0_in;
   dtoi_pkg::item_type slot1_ff, slot1_in;
   logic               push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = slot0_ff;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // slot0 is always the head; entries shift down on pop
   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case ({push, pop})
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               slot0_in = push_item;
            end else begin
               slot1_in = push_item;
            end
         end
         2'b01: begin
            count_in = count_ff - 2'd1;
            slot0_in = slot1_ff;
         end
         2'b11: begin
            // only reachable with one entry held
            slot0_in = push_item;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

[src/dtoi_back.sv]
// dtoi_back: parse engine; applies one classified character per unstalled cycle and
// builds the signed 128-bit result on the end marker. Depends on dtoi_pkg, dtoi_rsp_if.

module dtoi_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_ready,
   input  dtoi_pkg::item_type item,
   dtoi_rsp_if.source         rsp_ch
);

   logic [dtoi_pkg::MagWidth-1:0] mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic                          settled_ff, settled_in;
   logic                          saw_ff, saw_in;
   dtoi_pkg::status_type          error_ff, error_in;
   dtoi_pkg::phase_type           phase_ff, phase_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dtoi_pkg::ValWidth-1:0] value_ff, value_in;
   dtoi_pkg::status_type          status_ff, status_in;

   logic                          out_free;
   logic                          take;
   logic                          do_digit;
   logic                          at_limit;
   logic                          over_limit;
   logic [3:0]                    edge_digit;
   logic [dtoi_pkg::MagWidth-1:0] times10;
   logic [dtoi_pkg::ValWidth-1:0] mag_wide;

   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign item_ready = (item.cls != dtoi_pkg::CLS_END) || out_free;
   assign take       = item_valid && item_ready;

   // compare and shift-add run side by side off the registered magnitude
   assign at_limit   = (mag_ff == dtoi_pkg::MAG_LIMIT);
   assign over_limit = (mag_ff > dtoi_pkg::MAG_LIMIT);
   assign edge_digit = neg_ff ? dtoi_pkg::EDGE_NEG : dtoi_pkg::EDGE_POS;
   assign times10    = (mag_ff << 3) + (mag_ff << 1)
                       + {{(dtoi_pkg::MagWidth-4){1'b0}}, item.digit};
   assign mag_wide   = {1'b0, mag_ff};

   always_comb begin
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      settled_in   = settled_ff;
      saw_in       = saw_ff;
      error_in     = error_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      value_in     = value_ff;
      status_in    = status_ff;
      do_digit     = 1'b0;

      if (take) begin
         if (item.cls == dtoi_pkg::CLS_END) begin
            rsp_valid_in = 1'b1;
            value_in     = '0;
            if (!saw_ff) begin
               status_in = dtoi_pkg::ST_EMPTY;
            end else if (error_ff != dtoi_pkg::ST_OK) begin
               status_in = error_ff;
            end else begin
               status_in = dtoi_pkg::ST_OK;
               if (settled_ff) begin
                  value_in = neg_ff ? {1'b1, {(dtoi_pkg::ValWidth-1){1'b0}}}
                                    : {1'b0, {(dtoi_pkg::ValWidth-1){1'b1}}};
               end else if (neg_ff) begin
                  value_in = ~mag_wide + 128'd1;
               end else begin
                  value_in = mag_wide;
               end
            end
            // back to the reset state for the next string
            mag_in     = '0;
            neg_in     = 1'b0;
            settled_in = 1'b0;
            saw_in     = 1'b0;
            error_in   = dtoi_pkg::ST_OK;
            phase_in   = dtoi_pkg::PH_LEAD;
         end else begin
            saw_in = 1'b1;
            case (phase_ff)
               dtoi_pkg::PH_LEAD: begin
                  case (item.cls)
                     dtoi_pkg::CLS_SPACE: begin
                     end
                     dtoi_pkg::CLS_PLUS: begin
                        phase_in = dtoi_pkg::PH_DIGITS;
                     end
                     dtoi_pkg::CLS_MINUS: begin
                        neg_in   = 1'b1;
                        phase_in = dtoi_pkg::PH_DIGITS;
                     end
                     dtoi_pkg::CLS_DIGIT: begin
                        phase_in = dtoi_pkg::PH_DIGITS;
                        do_digit = 1'b1;
                     end
                     default: begin
                        error_in = dtoi_pkg::ST_INVALID;
                        phase_in = dtoi_pkg::PH_HALT;
                     end
                  endcase
               end
               dtoi_pkg::PH_DIGITS: begin
                  if (item.cls == dtoi_pkg::CLS_DIGIT) begin
                     do_digit = 1'b1;
                  end else begin
                     error_in = dtoi_pkg::ST_INVALID;
                     phase_in = dtoi_pkg::PH_HALT;
                  end
               end
               default: begin
                  // halted: characters are ignored
               end
            endcase

            if (do_digit) begin
               if (over_limit || (at_limit && (item.digit > edge_digit))) begin
                  error_in = dtoi_pkg::ST_RANGE;
                  phase_in = dtoi_pkg::PH_HALT;
               end else if (at_limit && (item.digit == edge_digit)) begin
                  settled_in = 1'b1;
                  phase_in   = dtoi_pkg::PH_HALT;
               end else begin
                  mag_in = times10;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff       <= '0;
         neg_ff       <= 1'b0;
         settled_ff   <= 1'b0;
         saw_ff       <= 1'b0;
         error_ff     <= dtoi_pkg::ST_OK;
         phase_ff     <= dtoi_pkg::PH_LEAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         mag_ff       <= mag_in;
         neg_ff       <= neg_in;
         settled_ff   <= settled_in;
         saw_ff       <= saw_in;
         error_ff     <= error_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.value_high = $signed(value_ff[dtoi_pkg::ValWidth-1:64]);
   assign rsp_ch.value_low  = value_ff[63:0];
   assign rsp_ch.status     = status_ff;

endmodule

[src/decimal_text_to_int128_parser.sv]
// Channel  Dir  Payload                                  Handshake
// req_ch   in   action (1), character (8)                valid/ready
// rsp_ch   out  value_high (s64), value_low (64), status  valid/ready
//
// Sustained rate is one character or end marker per unstalled cycle; the parse engine
// updates the 127-bit magnitude (x10 + digit) once per accepted digit.
// An end marker passes through the queue, and its result is registered at the output.
// Synchronous reset empties the queue, clears parse state and the output valid flag.
// A stalled result holds; characters of the next string keep flowing until its
// end marker, and the two-entry queue absorbs back-end stalls.
// Top level of the decimal text parser. Depends on dtoi_pkg, dtoi_if, dtoi_front,
// dtoi_queue and dtoi_back.

module decimal_text_to_int128_parser (
   input  logic       clock,
   input  logic       reset,
   dtoi_req_if.sink   req_ch,
   dtoi_rsp_if.source rsp_ch
);

   logic               push_valid, push_ready;
   dtoi_pkg::item_type push_item;
   logic               pop_valid, pop_ready;
   dtoi_pkg::item_type pop_item;

   dtoi_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   dtoi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   dtoi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item_ready (pop_ready),
      .item       (pop_item),
      .rsp_ch     (rsp_ch)
   );

endmodule

[src/dtoi_checker.sv]
// dtoi_checker: port-level checks on the decimal text parser, bound to the top level.
// Depends on dtoi_pkg and decimal_text_to_int128_parser.

module dtoi_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_value_high,
   input logic [63:0] rsp_value_low,
   input logic [1:0]  rsp_status
);

   // a stalled result transaction stays and holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_high)
                                 && $stable(rsp_value_low) && $stable(rsp_status))
      else $error("result changed while stalled");

   // error and empty results carry a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != dtoi_pkg::ST_OK)
         |-> (rsp_value_high == 64'd0) && (rsp_value_low == 64'd0))
      else $error("non-ok result with nonzero value");

   // nothing is presented right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind decimal_text_to_int128_parser dtoi_checker u_dtoi_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_value_high (rsp_ch.value_high),
   .rsp_value_low  (rsp_ch.value_low),
   .rsp_status     (rsp_ch.status)
);
